// ----- rtl/daltonize_color_filter_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the daltonization color filter
// Clocked concurrent checks that are switched off while reset is held.
// ----------------------------------------------------------------------------
`ifndef DALTONIZE_COLOR_FILTER_TOP_ASSERT_SVH
`define DALTONIZE_COLOR_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("daltonize color filter: same-cycle check failed");

// Next-cycle implication.
`define DCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("daltonize color filter: next-cycle check failed");

`endif

// ----- rtl/dcf_pkg.sv -----
// ----------------------------------------------------------------------------
// dcf_pkg
// Types, constants and coefficient helpers of the daltonization color filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

    // Component format: unsigned, one integer bit, 1.0 is 1 << C_COMP_FRAC.
    localparam int C_COMP_FRAC = 12;
    localparam int C_COMP_W    = C_COMP_FRAC + 1;
    localparam int C_ONE       = 1 << C_COMP_FRAC;

    // Extra fraction bits kept on intermediate color values.
    localparam int C_GUARD = 8;

    // Default coefficient fraction bits.
    localparam int C_COEF_FRAC = 16;

    // Filter mode register.
    localparam int C_MODE_W = 2;

    typedef enum logic [C_MODE_W-1:0] {
        MODE_NORMAL = 2'd0,
        MODE_PROTAN = 2'd1,
        MODE_DEUTAN = 2'd2,
        MODE_TRITAN = 2'd3
    } t_mode;

    typedef struct packed {
        logic [C_COMP_W-1:0] red_in;
        logic [C_COMP_W-1:0] green_in;
        logic [C_COMP_W-1:0] blue_in;
        logic [C_COMP_W-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [C_COMP_W-1:0] red_out;
        logic [C_COMP_W-1:0] green_out;
        logic [C_COMP_W-1:0] blue_out;
        logic [C_COMP_W-1:0] alpha_out;
    } t_pix_out;

    // Coefficients scaled by 2^24: RGB to LMS rows, the three cone
    // replacements, LMS to RGB rows and the red error gain of 0.7.
    localparam int C_NUM_COEF = 25;
    localparam longint C_COEF_Q24 [C_NUM_COEF] = '{
        300016887, 730079009, 69111225,
        57976186, 455592011, 64879843,
        502588, 3092192, 24613686,
        33947690, -42376060,
        8291418, 20942495,
        -6642318, 13440379,
        1358022, -2189501, 1958254,
        -171942, 906294, -1906138,
        -6129, -69149, 11635191,
        11744051
    };

    // Coefficient rounded half away from zero to kfb fraction bits.
    function automatic longint dcf_coef(input int idx, input int kfb);
        longint q;
        longint mag;
        int     sh;
        q  = C_COEF_Q24[idx];
        sh = 24 - kfb;
        if (sh == 0) begin
            return q;
        end
        mag = (q < 0) ? -q : q;
        mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
        return (q < 0) ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/daltonize_color_filter_top.sv -----
// ----------------------------------------------------------------------------
// daltonize_color_filter_top
// Color blindness simulation and compensation on an RGBA pixel stream.
//
// The block takes one pixel per clock and gives one pixel per clock while
// the output side does not stall. Every item passes through nine register
// stages in turn. Each stage holds one multiply or one add-and-round, and
// the last stage is the output register. A stall only holds stages that are
// occupied, so bubbles close up and the input keeps taking items while a
// result waits and any stage is empty. The filter mode is written through its
// own channel, which is always ready, and it should only change while no item
// is in flight. In normal mode pixels pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none
`include "daltonize_color_filter_top_assert.svh"

module daltonize_color_filter_top #(
    parameter int COEF_FRAC_BITS = dcf_pkg::C_COEF_FRAC
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Configuration write channel.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dcf_pkg::C_MODE_W-1:0]  i_cfg_data,
    // Input pixel channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire dcf_pkg::t_pix_in              i_in_pixel,
    // Output pixel channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output dcf_pkg::t_pix_out                  o_out_pixel
);

    import dcf_pkg::*;

    localparam int NSTG   = 9;
    localparam int CW     = COEF_FRAC_BITS + 7;        // signed coefficient
    localparam int PW     = C_COMP_W + 1;              // component as signed
    localparam int LW     = C_COMP_FRAC + C_GUARD + 9; // LMS and RGB values
    localparam int LW1    = LW + 1;
    localparam int LW2    = LW + 2;
    localparam int P1W    = CW + PW;
    localparam int S1W    = P1W + 2;
    localparam int P2W    = CW + LW;
    localparam int S2W    = P2W + 1;
    localparam int S4W    = P2W + 2;
    localparam int P6W    = CW + LW1;
    localparam int TO_LMS = COEF_FRAC_BITS - C_GUARD;

    localparam logic signed [S1W-1:0] RND_S1 = S1W'(longint'(1) << (TO_LMS - 1));
    localparam logic signed [S2W-1:0] RND_S3 = S2W'(longint'(1) << (COEF_FRAC_BITS - 1));
    localparam logic signed [S4W-1:0] RND_S5 = S4W'(longint'(1) << (COEF_FRAC_BITS - 1));
    localparam logic signed [P6W-1:0] RND_S7 = P6W'(longint'(1) << (COEF_FRAC_BITS - 1));
    localparam logic signed [LW2-1:0] RND_S8 = LW2'(longint'(1) << (C_GUARD - 1));

    // Coefficient at the chosen fraction width.
    function automatic logic signed [CW-1:0] kc(input int idx);
        return CW'(dcf_coef(idx, COEF_FRAC_BITS));
    endfunction

    // Clamp to 0..1.0.
    function automatic logic [C_COMP_W-1:0] sat_comp(input logic signed [LW2-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > LW2'(C_ONE)) begin
            return C_COMP_W'(C_ONE);
        end
        return C_COMP_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // Mode register
    // ------------------------------------------------------------------
    t_mode r_filter_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= MODE_NORMAL;
        end else if (i_cfg_valid) begin
            r_filter_mode <= t_mode'(i_cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and per-stage advance enables
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // A stage may load when it or any later stage is empty, or the output
    // register hands its item on.
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            w_en[k] = i_out_ready || ((r_vld >> k) != ({NSTG{1'b1}} >> k));
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Raw pixel and mode travel alongside each item.
    t_pix_in r_pix  [NSTG-1];
    t_mode   r_mode [NSTG];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_mode[0] <= r_filter_mode;
            r_pix[0]  <= i_in_pixel;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_mode[k] <= r_mode[k-1];
            end
        end
        for (int k = 1; k < NSTG - 1; k++) begin
            if (w_en[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: RGB times the LMS matrix, nine products
    // ------------------------------------------------------------------
    logic signed [P1W-1:0] n_p0 [9];
    logic signed [P1W-1:0] r_p0 [9];
    logic signed [PW-1:0]  w_rgb [3];

    always_comb begin
        w_rgb[0] = $signed({1'b0, i_in_pixel.red_in});
        w_rgb[1] = $signed({1'b0, i_in_pixel.green_in});
        w_rgb[2] = $signed({1'b0, i_in_pixel.blue_in});
        for (int i = 0; i < 9; i++) begin
            n_p0[i] = kc(i) * w_rgb[i % 3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p0 <= n_p0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sum each row and round to the LMS format
    // ------------------------------------------------------------------
    logic signed [LW-1:0] n_lms1 [3];
    logic signed [LW-1:0] r_lms1 [3];
    logic signed [S1W-1:0] w_sum1 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum1[i] = S1W'(r_p0[3*i]) + S1W'(r_p0[3*i+1]) + S1W'(r_p0[3*i+2]);
            n_lms1[i] = LW'((w_sum1[i] + RND_S1) >>> TO_LMS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_lms1 <= n_lms1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products that rebuild the missing cone response
    // ------------------------------------------------------------------
    logic signed [CW-1:0]  w_ka, w_kb;
    logic signed [LW-1:0]  w_xa, w_xb;
    logic signed [P2W-1:0] r_qa2, r_qb2;
    logic signed [LW-1:0]  r_lms2 [3];

    always_comb begin
        case (r_mode[1])
            MODE_PROTAN: begin
                w_ka = kc(9);
                w_kb = kc(10);
                w_xa = r_lms1[1];
                w_xb = r_lms1[2];
            end
            MODE_DEUTAN: begin
                w_ka = kc(11);
                w_kb = kc(12);
                w_xa = r_lms1[0];
                w_xb = r_lms1[2];
            end
            default: begin
                w_ka = kc(13);
                w_kb = kc(14);
                w_xa = r_lms1[0];
                w_xb = r_lms1[1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_qa2  <= w_ka * w_xa;
            r_qb2  <= w_kb * w_xb;
            r_lms2 <= r_lms1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: replace one cone response
    // ------------------------------------------------------------------
    logic signed [S2W-1:0] w_sum3;
    logic signed [LW-1:0]  w_rep3;
    logic signed [LW-1:0]  n_lms3 [3];
    logic signed [LW-1:0]  r_lms3 [3];

    always_comb begin
        w_sum3 = S2W'(r_qa2) + S2W'(r_qb2);
        w_rep3 = LW'((w_sum3 + RND_S3) >>> COEF_FRAC_BITS);
        n_lms3 = r_lms2;
        case (r_mode[2])
            MODE_PROTAN: n_lms3[0] = w_rep3;
            MODE_DEUTAN: n_lms3[1] = w_rep3;
            MODE_TRITAN: n_lms3[2] = w_rep3;
            default:     n_lms3    = r_lms2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_lms3 <= n_lms3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: LMS times the RGB matrix, nine products
    // ------------------------------------------------------------------
    logic signed [P2W-1:0] n_p4 [9];
    logic signed [P2W-1:0] r_p4 [9];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_p4[i] = kc(15 + i) * r_lms3[i % 3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_p4 <= n_p4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: simulated RGB
    // ------------------------------------------------------------------
    logic signed [S4W-1:0] w_sum5 [3];
    logic signed [LW-1:0]  n_sim5 [3];
    logic signed [LW-1:0]  r_sim5 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum5[i] = S4W'(r_p4[3*i]) + S4W'(r_p4[3*i+1]) + S4W'(r_p4[3*i+2]);
            n_sim5[i] = LW'((w_sum5[i] + RND_S5) >>> COEF_FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_sim5 <= n_sim5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: red error times 0.7, doubled green and blue minus simulation
    // ------------------------------------------------------------------
    logic signed [LW1-1:0] w_dr6;
    logic signed [P6W-1:0] r_e6;
    logic signed [LW1-1:0] r_dg6, r_db6;

    always_comb begin
        w_dr6 = (LW1'($signed({1'b0, r_pix[5].red_in})) <<< C_GUARD) - LW1'(r_sim5[0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_e6  <= kc(24) * w_dr6;
            r_dg6 <= (LW1'($signed({1'b0, r_pix[5].green_in})) <<< (C_GUARD + 1))
                     - LW1'(r_sim5[1]);
            r_db6 <= (LW1'($signed({1'b0, r_pix[5].blue_in})) <<< (C_GUARD + 1))
                     - LW1'(r_sim5[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: add the rounded red error to green and blue
    // ------------------------------------------------------------------
    logic signed [LW1-1:0] w_rerr7;
    logic signed [LW2-1:0] r_fg7, r_fb7;

    always_comb begin
        w_rerr7 = LW1'((r_e6 + RND_S7) >>> COEF_FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_fg7 <= LW2'(r_dg6) + LW2'(w_rerr7);
            r_fb7 <= LW2'(r_db6) + LW2'(w_rerr7);
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: round to the component format, clamp, output register
    // ------------------------------------------------------------------
    t_pix_out n_out;
    t_pix_out r_out;

    always_comb begin
        if (r_mode[7] == MODE_NORMAL) begin
            n_out.red_out   = r_pix[7].red_in;
            n_out.green_out = r_pix[7].green_in;
            n_out.blue_out  = r_pix[7].blue_in;
        end else begin
            n_out.red_out   = (r_pix[7].red_in > C_COMP_W'(C_ONE)) ?
                              C_COMP_W'(C_ONE) : r_pix[7].red_in;
            n_out.green_out = sat_comp((r_fg7 + RND_S8) >>> C_GUARD);
            n_out.blue_out  = sat_comp((r_fb7 + RND_S8) >>> C_GUARD);
        end
        n_out.alpha_out = r_pix[7].alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_out <= n_out;
        end
    end

    assign o_out_pixel = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted item always occupies the first stage on the next cycle.
    `DCF_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])

    // An item waiting in front of a stalled output stage is not dropped.
    `DCF_ASSERT_NXT(a_no_loss, i_clk, i_rst_n, r_vld[NSTG-2] && !w_en[NSTG-1],
        r_vld[NSTG-2])

    // Filtered results are always inside 0..1.0.
    `DCF_ASSERT_IMP(a_sat_range, i_clk, i_rst_n,
        o_out_valid && r_mode[NSTG-1] != MODE_NORMAL,
        o_out_pixel.red_out <= C_COMP_W'(C_ONE) && o_out_pixel.green_out <= C_COMP_W'(C_ONE)
        && o_out_pixel.blue_out <= C_COMP_W'(C_ONE))

    // The mode changes only through a configuration write.
    `DCF_ASSERT_NXT(a_mode_hold, i_clk, i_rst_n, !i_cfg_valid, $stable(r_filter_mode))

endmodule

`default_nettype wire
